FILE: rtl/tgs_pkg.sv
// ----------------------------------------------------------------------------
// tgs_pkg: shared types and constants of the trilinear grid sampler
// Holds the payload types, the register indexes and the fixed widths.
// ----------------------------------------------------------------------------
package tgs_pkg;

  localparam int POS_W       = 24;
  localparam int VAL_W       = 8;
  localparam int STORE_AW    = 12;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int CNT_W       = 5;
  localparam int CNTS_W      = 3 * CNT_W;
  localparam int FRAC_BITS   = 12;
  localparam int BLEND_SHIFT = 3 * FRAC_BITS;
  localparam int SUM_W       = BLEND_SHIFT + VAL_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = POS_W;
  localparam int MAX_DIM_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X       = 3'd0,
    REG_MIN_Y       = 3'd1,
    REG_MIN_Z       = 3'd2,
    REG_MAX_X       = 3'd3,
    REG_MAX_Y       = 3'd4,
    REG_MAX_Z       = 3'd5,
    REG_GRID_COUNTS = 3'd6
  } cfg_reg_e;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [STORE_AW-1:0]     entry_index;
    logic [VAL_W-1:0]        entry_value;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] visibility_out;
  } rsp_t;

  // Item control that travels with every pipeline stage.
  typedef struct packed {
    logic                act;
    logic [STORE_AW-1:0] idx;
    logic [VAL_W-1:0]    val;
    logic                zc;
  } item_t;

endpackage

FILE: rtl/tgs_stream_if.sv
// ----------------------------------------------------------------------------
// tgs_stream_if: valid/ready stream channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface tgs_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/trilinear_grid_sampler_top.sv
// ----------------------------------------------------------------------------
// trilinear_grid_sampler_top: trilinear sampler over a 3-D byte grid
// Stores grid entries and blends eight neighbors for each sample position.
// ----------------------------------------------------------------------------
// The block takes one item per clock on req and gives one result per sample
// item on rsp, in order; a write item stores entry_value at entry_index and
// gives no result. The per-axis divider has QW = clog2(MAX_DIM) + 12
// quotient bits: one divider stage resolves one quotient bit, and the
// three axes run in parallel dividers. The grid store is kept in eight
// identical RAM copies, all written together, so that the eight neighbors
// of a sample are read together. Throughput is one item per cycle; the
// whole pipeline holds while a finished result waits on rsp, and req.ready
// follows that condition. A sample reads entries written by any earlier
// accepted write. Configuration may be written only while no item is in
// flight.
module trilinear_grid_sampler_top
  import tgs_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tgs_stream_if.sink            req,
  tgs_stream_if.source          rsp
);

  // Count width, index width and quotient width all follow from MAX_DIM.
  localparam int NW = $clog2(MAX_DIM + 1);
  localparam int NB = $clog2(MAX_DIM);
  localparam int QW = NB + FRAC_BITS;
  localparam int PW = POS_W + NB;
  localparam int WW = FRAC_BITS + 1;
  localparam int XW = 2 * WW;
  localparam int VW = VAL_W + WW;
  localparam int DIFF_W = POS_W + 1;

  typedef struct packed {
    item_t                   it;
    logic [2:0][NW-1:0]      n;
    logic [2:0]              low;
    logic [2:0]              high;
  } side_t;

  // Configuration registers.
  logic signed [POS_W-1:0] min_r [3];
  logic signed [POS_W-1:0] max_r [3];
  logic [CNTS_W-1:0]       grid_counts;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        min_r[a] <= '0;
        max_r[a] <= '0;
      end
      grid_counts <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_X:       min_r[0] <= cfg_data;
        REG_MIN_Y:       min_r[1] <= cfg_data;
        REG_MIN_Z:       min_r[2] <= cfg_data;
        REG_MAX_X:       max_r[0] <= cfg_data;
        REG_MAX_Y:       max_r[1] <= cfg_data;
        REG_MAX_Z:       max_r[2] <= cfg_data;
        REG_GRID_COUNTS: grid_counts <= cfg_data[CNTS_W-1:0];
        default:         ;
      endcase
    end
  end

  // The pipeline moves as one unit; it holds only while a result waits.
  logic adv;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // Stage 1: offsets from the lower bounds, ranges and saturated counts.
  logic                     s1_v;
  item_t                    s1_it;
  logic signed [DIFF_W-1:0] s1_d [3];
  logic signed [DIFF_W-1:0] s1_r [3];
  logic [NW-1:0]            s1_n [3];
  logic signed [POS_W-1:0]  pos_in [3];
  logic [CNT_W-1:0]         cnt_raw [3];
  logic [NW-1:0]            cnt_sat [3];

  always_comb begin
    pos_in[0] = req.payload.pos_x;
    pos_in[1] = req.payload.pos_y;
    pos_in[2] = req.payload.pos_z;
    for (int a = 0; a < 3; a++) begin
      cnt_raw[a] = grid_counts[a*CNT_W +: CNT_W];
      cnt_sat[a] = (int'(cnt_raw[a]) > MAX_DIM) ? NW'(MAX_DIM) : NW'(cnt_raw[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_it.act <= req.payload.action;
      s1_it.idx <= req.payload.entry_index;
      s1_it.val <= req.payload.entry_value;
      s1_it.zc  <= (cnt_sat[0] == '0) || (cnt_sat[1] == '0) || (cnt_sat[2] == '0);
      for (int a = 0; a < 3; a++) begin
        s1_d[a] <= DIFF_W'(pos_in[a]) - DIFF_W'(min_r[a]);
        s1_r[a] <= DIFF_W'(max_r[a]) - DIFF_W'(min_r[a]);
        s1_n[a] <= cnt_sat[a];
      end
    end
  end

  // Stage 2: edge flags and the scaled offset d * (count - 1).
  logic             s2_v;
  side_t            s2_side;
  logic [PW-1:0]    s2_prod [3];
  logic [POS_W-1:0] s2_den [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side.it <= s1_it;
      for (int a = 0; a < 3; a++) begin
        s2_side.n[a]    <= s1_n[a];
        s2_side.low[a]  <= (s1_n[a] <= NW'(1)) || (s1_r[a] <= 0) || (s1_d[a] <= 0);
        s2_side.high[a] <= s1_d[a] >= s1_r[a];
        s2_prod[a]      <= PW'(s1_d[a][POS_W-1:0]) * PW'(NB'(s1_n[a] - NW'(1)));
        s2_den[a]       <= s1_r[a][POS_W-1:0];
      end
    end
  end

  // Divider stages: one per axis, the item side data runs alongside.
  logic [QW-1:0] quo [3];
  logic          dv_v;
  side_t         dv_side;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    tgs_div #(.NB(NB)) u_div (
      .clk  (clk),
      .en   (adv),
      .prod (s2_prod[a]),
      .den  (s2_den[a]),
      .quo  (quo[a])
    );
  end

  tgs_delay #(.WIDTH($bits(side_t)), .DEPTH(QW)) u_side (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (s2_v),
    .data_in  (s2_side),
    .vld_out  (dv_v),
    .data_out (dv_side)
  );

  // Stage C: grid coordinate, neighbor indexes and weights.
  logic          c_v;
  item_t         c_it;
  logic [NW-1:0] c_n [3];
  logic [NB-1:0] c_i [3][2];
  logic [WW-1:0] c_w [3][2];
  logic [QW-1:0] coord [3];
  logic [NB-1:0] lo_idx [3];
  logic [NW:0]   lo_inc [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (dv_side.low[a]) begin
        coord[a] = '0;
      end else if (dv_side.high[a]) begin
        coord[a] = {NB'(dv_side.n[a] - NW'(1)), {FRAC_BITS{1'b0}}};
      end else begin
        coord[a] = quo[a];
      end
      lo_idx[a] = coord[a][QW-1:FRAC_BITS];
      lo_inc[a] = (NW+1)'(lo_idx[a]) + (NW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_it <= dv_side.it;
      for (int a = 0; a < 3; a++) begin
        c_n[a]    <= dv_side.n[a];
        c_i[a][0] <= lo_idx[a];
        // The upper neighbor stays on the last grid point.
        c_i[a][1] <= (lo_inc[a] < (NW+1)'(dv_side.n[a])) ? NB'(lo_inc[a])
                                                          : NB'(dv_side.n[a] - NW'(1));
        c_w[a][1] <= WW'(coord[a][FRAC_BITS-1:0]);
        c_w[a][0] <= WW'(1 << FRAC_BITS) - WW'(coord[a][FRAC_BITS-1:0]);
      end
    end
  end

  // Stage D: partial row addresses and the x-y weight products.
  logic                d_v;
  item_t               d_it;
  logic [NW-1:0]       d_nx;
  logic [NB-1:0]       d_x [2];
  logic [WW-1:0]       d_wz [2];
  logic [STORE_AW-1:0] d_zy [2][2];
  logic [XW-1:0]       d_wxy [2][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_it <= c_it;
      d_nx <= c_n[0];
      for (int i = 0; i < 2; i++) begin
        d_x[i]  <= c_i[0][i];
        d_wz[i] <= c_w[2][i];
        for (int j = 0; j < 2; j++) begin
          d_zy[i][j]  <= STORE_AW'(STORE_AW'(c_i[2][i]) * STORE_AW'(c_n[1])
                                   + STORE_AW'(c_i[1][j]));
          d_wxy[j][i] <= XW'(c_w[0][j]) * XW'(c_w[1][i]);
        end
      end
    end
  end

  // Stage E: eight full addresses; write items reach the store here.
  logic                e_v;
  item_t               e_it;
  logic [WW-1:0]       e_wz [2];
  logic [XW-1:0]       e_wxy [2][2];
  logic [STORE_AW-1:0] e_addr [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_it  <= d_it;
      e_wz  <= d_wz;
      e_wxy <= d_wxy;
      for (int c = 0; c < 2; c++) begin
        for (int b = 0; b < 2; b++) begin
          for (int a = 0; a < 2; a++) begin
            e_addr[c*4 + b*2 + a] <= STORE_AW'(d_zy[c][b] * STORE_AW'(d_nx)
                                               + STORE_AW'(d_x[a]));
          end
        end
      end
    end
  end

  logic             ram_we;
  logic [VAL_W-1:0] ram_q [8];

  assign ram_we = adv && e_v && (e_it.act == ACT_WRITE);

  for (genvar k = 0; k < 8; k++) begin : g_bank
    tgs_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (e_it.idx),
      .wdata (e_it.val),
      .re    (adv),
      .raddr (e_addr[k]),
      .rdata (ram_q[k])
    );
  end

  // Stage M: neighbor values arrive from the store.
  logic          m_v;
  item_t         m_it;
  logic [WW-1:0] m_wz [2];
  logic [XW-1:0] m_wxy [2][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_it  <= e_it;
      m_wz  <= e_wz;
      m_wxy <= e_wxy;
    end
  end

  // Stage B1: value times z weight.
  logic          b1_v;
  item_t         b1_it;
  logic [XW-1:0] b1_wxy [2][2];
  logic [VW-1:0] b1_pv [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (adv) begin
      b1_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_it  <= m_it;
      b1_wxy <= m_wxy;
      for (int k = 0; k < 8; k++) begin
        b1_pv[k] <= VW'(ram_q[k]) * VW'(m_wz[k/4]);
      end
    end
  end

  // Stage B2: full weighted terms. The x-y weight table is indexed by the
  // x neighbor first, then by the y neighbor.
  logic             b2_v;
  item_t            b2_it;
  logic [SUM_W-1:0] b2_term [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_v <= 1'b0;
    end else if (adv) begin
      b2_v <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_it <= b1_it;
      for (int k = 0; k < 8; k++) begin
        b2_term[k] <= SUM_W'(b1_pv[k]) * SUM_W'(b1_wxy[k%2][(k/2)%2]);
      end
    end
  end

  // Stage B3: first level of the sum; the total never exceeds 255 * 2^36.
  logic             b3_v;
  item_t            b3_it;
  logic [SUM_W-1:0] b3_sum [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_v <= 1'b0;
    end else if (adv) begin
      b3_v <= b2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_it <= b2_it;
      for (int j = 0; j < 4; j++) begin
        b3_sum[j] <= SUM_W'(b2_term[2*j] + b2_term[2*j+1]);
      end
    end
  end

  // Output register: final sum, round half up, clamp.
  logic [SUM_W:0]     total;
  logic [VAL_W:0]     rounded;
  logic [VAL_W-1:0]   vis;

  always_comb begin
    total   = (SUM_W+1)'(b3_sum[0]) + (SUM_W+1)'(b3_sum[1])
            + (SUM_W+1)'(b3_sum[2]) + (SUM_W+1)'(b3_sum[3])
            + (SUM_W+1)'(64'd1 << (BLEND_SHIFT - 1));
    rounded = total[SUM_W:BLEND_SHIFT];
    if (b3_it.zc || rounded[VAL_W]) begin
      vis = '1;
    end else begin
      vis = rounded[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= b3_v && (b3_it.act == ACT_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.payload.visibility_out <= vis;
    end
  end

  // A held result freezes the store: no write may slip past a stall.
  assert property (@(posedge clk) disable iff (rst) !adv |-> !ram_we)
    else $error("store written while the pipeline is held");

  // Write items never turn into a result transfer.
  assert property (@(posedge clk) disable iff (rst)
    adv && b3_v && (b3_it.act == ACT_WRITE) |=> !rsp.valid)
    else $error("write item produced a result");

  // Inside the grid range the x quotient stays below (count - 1) << 12.
  assert property (@(posedge clk) disable iff (rst)
    dv_v && (dv_side.it.act == ACT_SAMPLE) && !dv_side.it.zc
      && !dv_side.low[0] && !dv_side.high[0]
      |-> quo[0] < {NB'(dv_side.n[0] - NW'(1)), {FRAC_BITS{1'b0}}})
    else $error("x coordinate beyond the last grid point");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("result valid right after reset");

endmodule

FILE: rtl/tgs_ram.sv
// ----------------------------------------------------------------------------
// tgs_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tgs_delay.sv
// ----------------------------------------------------------------------------
// tgs_delay: enabled delay line
// Moves a valid bit and a data word through DEPTH register stages.
// ----------------------------------------------------------------------------
module tgs_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vld_in,
  input  logic [WIDTH-1:0] data_in,
  output logic             vld_out,
  output logic [WIDTH-1:0] data_out
);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [DEPTH-1:0] vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_q[0] <= data_in;
      for (int k = 1; k < DEPTH; k++) begin
        data_q[k] <= data_q[k-1];
      end
    end
  end

  assign vld_out  = vld_q[DEPTH-1];
  assign data_out = data_q[DEPTH-1];

endmodule

FILE: rtl/tgs_div.sv
// ----------------------------------------------------------------------------
// tgs_div: pipelined restoring divider
// Produces one quotient bit per stage; the quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module tgs_div
  import tgs_pkg::*;
#(
  parameter int NB = 4
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [POS_W+NB-1:0]           prod,
  input  logic [POS_W-1:0]              den,
  output logic [NB+FRAC_BITS-1:0]       quo
);

  localparam int QW = NB + FRAC_BITS;
  localparam int DW = POS_W;

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] low_i;
    logic [QW-1:0] quo_i;
    logic [DW:0]   trial;

    if (k == 0) begin : g_first
      // The numerator is prod shifted left by the fraction bits.
      assign rem_i = prod[POS_W+NB-1:NB];
      assign den_i = den;
      assign low_i = {prod[NB-1:0], {FRAC_BITS{1'b0}}};
      assign quo_i = '0;
    end else begin : g_next
      assign rem_i = rem_q[k-1];
      assign den_i = den_q[k-1];
      assign low_i = low_q[k-1];
      assign quo_i = quo_q[k-1];
    end

    assign trial = {rem_i, low_i[QW-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k] <= den_i;
        low_q[k] <= {low_i[QW-2:0], 1'b0};
        if (trial >= {1'b0, den_i}) begin
          rem_q[k] <= DW'(trial - {1'b0, den_i});
          quo_q[k] <= {quo_i[QW-2:0], 1'b1};
        end else begin
          rem_q[k] <= DW'(trial);
          quo_q[k] <= {quo_i[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

FILE: tb/tb_trilinear_grid_sampler_top.sv
// ----------------------------------------------------------------------------
// tb_trilinear_grid_sampler_top: self-checking bench of the grid sampler
// Streams grid writes and sample positions through several bound and count
// settings, predicts each sampled visibility byte in a scoreboard class and
// compares it with every transfer that leaves the block.
// ----------------------------------------------------------------------------
module tb_trilinear_grid_sampler_top;
  import tgs_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int SETTLE_CYCLES = 40;     // outlasts the path of an item through the pipeline
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 540;
  localparam int NUM_PHASES = 6;

  // Scoreboard: keeps its own copy of the grid and of the registers and
  // predicts the byte that each accepted sample must produce.
  class visibility_scoreboard;
    logic [VAL_W-1:0] grid[STORE_DEPTH];
    logic signed [POS_W-1:0] lo[3] = '{0, 0, 0};
    logic signed [POS_W-1:0] hi[3] = '{0, 0, 0};
    logic [CNTS_W-1:0] counts = '0;
    logic [VAL_W-1:0] expected_q[$];
    int errors = 0;
    int checked = 0;

    function void set_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] d);
      case (r)
        REG_MIN_X: lo[0] = d;
        REG_MIN_Y: lo[1] = d;
        REG_MIN_Z: lo[2] = d;
        REG_MAX_X: hi[0] = d;
        REG_MAX_Y: hi[1] = d;
        REG_MAX_Z: hi[2] = d;
        default: counts = d[CNTS_W-1:0];
      endcase
    endfunction

    function int unsigned axis_points(int a);
      int unsigned c;
      c = (counts >> (CNT_W * a)) & 31;
      return (c > MAX_DIM_DEF) ? MAX_DIM_DEF : c;
    endfunction

    // Grid coordinate of one axis with FRAC_BITS fraction bits.
    function longint axis_coord(logic signed [POS_W-1:0] p, int a, int unsigned n);
      longint d, r;
      d = longint'(p) - longint'(lo[a]);
      r = longint'(hi[a]) - longint'(lo[a]);
      if (n <= 1 || r <= 0 || d <= 0) return 0;
      if (d >= r) return longint'(n - 1) << FRAC_BITS;
      return (d * longint'(n - 1) * 4096) / r;
    endfunction

    function logic [VAL_W-1:0] blend(req_t it);
      logic signed [POS_W-1:0] p[3];
      int unsigned n[3], i0[3], i1[3], ix, iy, iz;
      longint unsigned w1[3], wa, wb, wc, sum, res;
      longint cc;
      p = '{it.pos_x, it.pos_y, it.pos_z};
      for (int a = 0; a < 3; a++) n[a] = axis_points(a);
      if (n[0] == 0 || n[1] == 0 || n[2] == 0) return 8'd255;
      for (int a = 0; a < 3; a++) begin
        cc = axis_coord(p[a], a, n[a]);
        i0[a] = cc >> FRAC_BITS;
        i1[a] = (i0[a] + 1 < n[a]) ? i0[a] + 1 : n[a] - 1;
        w1[a] = cc & 12'hFFF;
      end
      sum = 0;
      for (int z = 0; z < 2; z++)
        for (int y = 0; y < 2; y++)
          for (int x = 0; x < 2; x++) begin
            ix = x ? i1[0] : i0[0];
            iy = y ? i1[1] : i0[1];
            iz = z ? i1[2] : i0[2];
            wa = x ? w1[0] : 4096 - w1[0];
            wb = y ? w1[1] : 4096 - w1[1];
            wc = z ? w1[2] : 4096 - w1[2];
            sum += longint'(grid[((iz * n[1] + iy) * n[0] + ix) & (STORE_DEPTH - 1)])
                   * wa * wb * wc;
          end
      res = (sum + (64'd1 << (BLEND_SHIFT - 1))) >> BLEND_SHIFT;
      return (res > 255) ? 8'd255 : res[VAL_W-1:0];
    endfunction

    function void note_input(req_t it);
      if (it.action == ACT_WRITE) grid[it.entry_index] = it.entry_value;
      else expected_q.push_back(blend(it));
    endfunction

    function void check_result(rsp_t r);
      logic [VAL_W-1:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, r.visibility_out);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (r.visibility_out !== want) begin
        $display("%0t: visibility mismatch, expected %0d, actual %0d",
                 $time, want, r.visibility_out);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tgs_stream_if #(.T(req_t)) req_ch ();
  tgs_stream_if #(.T(rsp_t)) rsp_ch ();

  trilinear_grid_sampler_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  visibility_scoreboard sb = new();

  // Entries that the bench has written; a sample may only touch these.
  bit written[STORE_DEPTH];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int n_writes = 0;
  int n_samples = 0;
  int n_configs = 0;

  // Both monitors sample the handshake at the rising edge, before any
  // nonblocking update of that edge has landed.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) sb.note_input(req_ch.payload);
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
  end

  // Receiver: random back-pressure, plus a long hold-off whenever the main
  // process asks for one by bumping hold_token. The hold is counted here.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: counts cycles in which no transfer happens on either side.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, sb.expected_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offers one item, with random gaps before it, and waits for its transfer.
  // The valid is left high so that back-to-back items need no extra edge.
  task automatic send_item(req_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (it.action == ACT_WRITE) begin
      written[it.entry_index] = 1'b1;
      n_writes++;
    end else begin
      n_samples++;
    end
  endtask

  task automatic write_entry(int unsigned idx, int unsigned v);
    req_t it;
    it = '0;
    it.action = ACT_WRITE;
    it.entry_index = idx;
    it.entry_value = v;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    send_item(it);
  endtask

  task automatic sample_at(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z);
    req_t it;
    it = '0;
    it.action = ACT_SAMPLE;
    it.entry_index = $urandom;
    it.entry_value = $urandom;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    send_item(it);
  endtask

  // Sender pauses until every expected result has come out, then lets the
  // pipeline settle so that trailing writes are finished too.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all seven registers in consecutive cycles; the block is idle here.
  task automatic configure(int mnx, int mny, int mnz, int mxx, int mxy, int mxz,
                           int unsigned nx, int unsigned ny, int unsigned nz);
    logic [CFG_DATA_W-1:0] vals[7];
    vals = '{mnx, mny, mnz, mxx, mxy, mxz, (nz << 10) | (ny << 5) | nx};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_reg_e'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(cfg_reg_e'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    n_configs++;
  endtask

  // Fills every entry that the current counts can reach and that is still
  // unwritten, so that no sample ever reads an undefined entry.
  task automatic fill_grid();
    int unsigned n;
    n = sb.axis_points(0) * sb.axis_points(1) * sb.axis_points(2);
    for (int unsigned i = 0; i < n && i < STORE_DEPTH; i++)
      if (!written[i]) write_entry(i, $urandom_range(255));
  endtask

  // Position on one axis: mostly inside the bounds, some on them, some just
  // outside, and some anywhere in the 24-bit range.
  function automatic logic [POS_W-1:0] pick_pos(int a);
    longint l, h;
    int unsigned pick;
    l = sb.lo[a];
    h = sb.hi[a];
    pick = $urandom_range(99);
    if (pick < 55 && h > l) return l + ({32'd0, $urandom} % (h - l + 1));
    if (pick < 70) return $urandom_range(1) ? l : h;
    if (pick < 80) return $urandom_range(1) ? l - 1 - $urandom_range(255)
                                            : h + 1 + $urandom_range(255);
    return $urandom;
  endfunction

  initial begin
    int unsigned nx, ny, nz;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    recv_idle_pct = 20;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. With all counts at their reset value of zero every sample
    // must give full visibility; writes at the index extremes go in as well.
    sample_at(24'h7FFFFF, 24'h800000, 24'h000000);
    sample_at(24'h800000, 24'h7FFFFF, 24'hFFFFFF);
    write_entry(STORE_DEPTH - 1, 255);
    write_entry(0, 0);
    drain();

    // A small 2x3x4 grid: corners, outside on both sides and a midpoint.
    configure(-1024, -256, 0, 1024, 256, 4096, 2, 3, 4);
    fill_grid();
    sample_at(-1024, -256, 0);
    sample_at(1024, 256, 4096);
    sample_at(-5000, -5000, -5000);
    sample_at(5000, 5000, 5000);
    sample_at(0, 0, 2048);
    sample_at(512, -100, 1000);
    write_entry(5, 255);
    sample_at(1024, 0, 0);
    drain();

    // Counts above the maximum saturate, a single point and an inverted
    // range give coordinate zero, and a zero count on one axis gives 255.
    configure(24'h7FFFFF, -8388608, 100, 24'h800000, 8388607, 100, 31, 17, 1);
    fill_grid();
    sample_at(0, 24'h7FFFFF, 100);
    sample_at(24'h7FFFFF, 24'h800000, 0);
    sample_at(12345, 0, -7);
    drain();
    configure(0, 0, 0, 256, 256, 256, 4, 0, 4);
    sample_at(128, 128, 128);
    sample_at(24'h7FFFFF, 0, 0);
    drain();

    // Random part in phases. Each phase takes its own setting; the idle pattern
    // moves from a slow receiver to a slow sender to no idling at all.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 31; recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: configure(-1000, -500, 0, 1000, 500, 2560, 3, 2, 5);
        1: configure(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 16, 4, 4);
        2: configure(24'h7FFFFF, -3000, 0, 24'h800000, 3000, 0, 31, 17, 1);
        3: configure(0, -256, 0, 256, 256, 256, 4, 0, 4);
        4: begin
          nx = $urandom_range(16, 1);
          ny = $urandom_range(4, 1);
          nz = $urandom_range(4, 1);
          configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, nx, ny, nz);
        end
        default: configure(777, 777, 777, 777, 777, 777, 2, 2, 2);
      endcase
      fill_grid();
      for (int k = 0; k < RANDOM_ITEMS / NUM_PHASES; k++) begin
        // In the first phase the receiver stalls for a long stretch while the
        // sender keeps offering, so the pipeline fills and holds its input.
        if (ph == 0 && k == 20) hold_token++;
        if ($urandom_range(99) < 25) write_entry($urandom, $urandom);
        else sample_at(pick_pos(0), pick_pos(1), pick_pos(2));
      end
      drain();
    end

    $display("Covered %0d samples and %0d grid writes over %0d register settings,",
             n_samples, n_writes, n_configs);
    $display("with %0d results checked against the predicted blend.", sb.checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
